@@ src/fbt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbt_pkg: shared types and constants for the failure backoff table
// Command codes, table geometry, controller commands and the interval table.
// ----------------------------------------------------------------------------
package fbt_pkg;

  // Table geometry
  localparam int SLOTS  = 256;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Saturation limits
  localparam logic [3:0] COUNT_MAX = 4'd15;
  localparam logic [3:0] LEVEL_MAX = 4'd8;

  // Command codes (code 3 acts as a query)
  localparam logic [1:0] CMD_FAIL    = 2'd0;
  localparam logic [1:0] CMD_SUCCESS = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;

  // Result status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch request, issue table read
    logic commit;   // write back entry, register result
  } fbt_ctrl_t;

  // One table entry
  typedef struct packed {
    logic [3:0]  count;
    logic [3:0]  level;
    logic [31:0] retry;
  } fbt_entry_t;

  // Backoff interval in hours for level 1..8 (index is level - 1)
  function automatic logic [31:0] fbt_interval(input logic [2:0] idx);
    logic [31:0] hrs;
    case (idx)
      3'd0:    hrs = 32'd1;
      3'd1:    hrs = 32'd4;
      3'd2:    hrs = 32'd12;
      3'd3:    hrs = 32'd24;
      3'd4:    hrs = 32'd72;
      3'd5:    hrs = 32'd168;
      3'd6:    hrs = 32'd336;
      3'd7:    hrs = 32'd731;
      default: hrs = 32'd1;
    endcase
    return hrs;
  endfunction

endpackage
`default_nettype wire

@@ src/fbt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbt_ctrl: request sequencer
// Two-state controller: accept a request, then commit it in the following cycle.
// ----------------------------------------------------------------------------
module fbt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  output logic                   done,
  output fbt_pkg::fbt_ctrl_t     cmd
);
  import fbt_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic state;
  logic state_next;

  // Handshake and commands
  assign busy        = (state == ST_CALC);
  assign cmd.capture = start && !busy;
  assign cmd.commit  = (state == ST_CALC);

  // Next state
  always_comb begin
    case (state)
      ST_IDLE: state_next = cmd.capture ? ST_CALC : ST_IDLE;
      ST_CALC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.commit;
    end
  end

`ifndef SYNTHESIS
  a_capture_commits: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> cmd.commit)
    else $error("accepted beat not committed next cycle");
  a_commit_strobes: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> done)
    else $error("commit without result strobe");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && !cmd.commit)
    else $error("result strobe while still busy");
`endif

endmodule
`default_nettype wire

@@ src/fbt_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbt_dpath: table storage and update arithmetic
// Holds the slot table with per-slot valid bits, the enable register, and
// computes the read-modify-write and the blocked/remaining-time result.
// ----------------------------------------------------------------------------
module fbt_dpath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire fbt_pkg::fbt_ctrl_t cmd,
  input  wire logic               cfg_wr,
  input  wire logic               cfg_data,
  input  wire logic [1:0]         command,
  input  wire logic [7:0]         slot_index,
  input  wire logic [31:0]        now_hours,
  output logic                    status,
  output logic                    blocked,
  output logic [31:0]             hours_until_retry,
  output logic [3:0]              count_after,
  output logic [3:0]              level_after
);
  import fbt_pkg::*;

  fbt_entry_t        mem [SLOTS];
  logic [SLOTS-1:0]  valid;
  logic              tracking_enabled;

  // Latched request
  logic [1:0]        cmd_q;
  logic [SLOT_W-1:0] slot_q;
  logic [31:0]       now_q;
  logic              ok_q;
  fbt_entry_t        rd_entry;
  logic              rd_valid;

  logic [SLOT_W-1:0] idx;
  logic              in_range;
  fbt_entry_t        cur;
  fbt_entry_t        upd;
  logic              write_en;
  logic [3:0]        cnt_inc;
  logic [31:0]       ivl;
  logic [32:0]       fail_sum;
  logic [32:0]       diff;
  logic              blk_calc;
  logic [31:0]       rem_calc;

  assign idx      = slot_index[SLOT_W-1:0];
  assign in_range = ({1'b0, slot_index} < 9'(SLOTS));

  // Enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      tracking_enabled <= 1'b0;
    end else if (cfg_wr) begin
      tracking_enabled <= cfg_data;
    end
  end

  // Request capture and registered table read
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q    <= command;
      slot_q   <= idx;
      now_q    <= now_hours;
      ok_q     <= tracking_enabled && in_range;
      rd_entry <= mem[idx];
      rd_valid <= valid[idx];
    end
  end

  // Entry as stored; never-written slots read as clean
  assign cur = rd_valid ? rd_entry : '0;

  // Update and result arithmetic
  always_comb begin
    cnt_inc  = (cur.count < COUNT_MAX) ? 4'(cur.count + 4'd1) : cur.count;
    upd      = cur;
    upd.level = (cnt_inc > LEVEL_MAX) ? LEVEL_MAX : cnt_inc;
    ivl      = fbt_interval(3'(upd.level - 4'd1));
    fail_sum = {1'b0, now_q} + {1'b0, ivl};
    diff     = {1'b0, cur.retry} - {1'b0, now_q};
    write_en = 1'b0;
    blk_calc = 1'b0;
    rem_calc = '0;
    case (cmd_q)
      CMD_FAIL: begin
        write_en  = 1'b1;
        upd.count = cnt_inc;
        upd.retry = fail_sum[31:0];
        // no wrap means now < retry, remaining is the interval
        blk_calc  = !fail_sum[32];
        rem_calc  = fail_sum[32] ? 32'd0 : ivl;
      end
      CMD_SUCCESS: begin
        write_en = 1'b1;
        upd      = '0;
      end
      default: begin
        upd      = cur;
        blk_calc = (cur.count != 4'd0) && !diff[32] && (diff[31:0] != 32'd0);
        rem_calc = blk_calc ? diff[31:0] : 32'd0;
      end
    endcase
  end

  // Table write-back
  always_ff @(posedge clk) begin
    if (cmd.commit && ok_q && write_en) begin
      mem[slot_q] <= upd;
    end
  end

  // Valid bits: reset marks the whole table clean
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.commit && ok_q && write_en) begin
      valid[slot_q] <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (ok_q) begin
        status            <= STATUS_OK;
        blocked           <= blk_calc;
        hours_until_retry <= rem_calc;
        count_after       <= upd.count;
        level_after       <= upd.level;
      end else begin
        status            <= STATUS_INVALID;
        blocked           <= 1'b0;
        hours_until_retry <= '0;
        count_after       <= '0;
        level_after       <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && !ok_q |=> status && !blocked && (hours_until_retry == 32'd0)
      && (count_after == 4'd0) && (level_after == 4'd0))
    else $error("invalid result carries nonzero fields");
  a_success_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && ok_q && (cmd_q == CMD_SUCCESS) |=> !blocked
      && (count_after == 4'd0) && (level_after == 4'd0))
    else $error("success did not clear slot");
  a_fail_level: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && ok_q && (cmd_q == CMD_FAIL) |=> (count_after != 4'd0)
      && (level_after != 4'd0) && (level_after <= LEVEL_MAX))
    else $error("failure produced bad count or level");
`endif

endmodule
`default_nettype wire

@@ src/failure_backoff_table.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// failure_backoff_table: per-slot failure tracking with exponential backoff
// Timing: done is registered from the commit state that follows the accept; busy
// is high in that commit state, so no new request is taken until the single-port
// table read-modify-write is through (read at accept, write-back at commit).
// Reset: synchronous; valid bits clear the whole table at once, no sweep.
// Results are shown for one cycle on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module failure_backoff_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  slot_index,
  input  wire logic [31:0] now_hours,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  output logic             done,
  output logic             status,
  output logic             blocked,
  output logic [31:0]      hours_until_retry,
  output logic [3:0]       count_after,
  output logic [3:0]       level_after
);
  import fbt_pkg::*;

  fbt_ctrl_t ctrl_cmd;

  // Config beats are always taken
  assign cfg_ready = 1'b1;

  // Sequencer
  fbt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (ctrl_cmd)
  );

  // Table and arithmetic
  fbt_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (ctrl_cmd),
    .cfg_wr            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .command           (command),
    .slot_index        (slot_index),
    .now_hours         (now_hours),
    .status            (status),
    .blocked           (blocked),
    .hours_until_retry (hours_until_retry),
    .count_after       (count_after),
    .level_after       (level_after)
  );

endmodule
`default_nettype wire

@@ verif/failure_backoff_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// failure_backoff_table_tb: self-checking bench for the failure backoff table
// Drives fail, success and query requests through the start/busy port and
// toggles tracking through the config channel. A shadow copy of the table
// predicts every answer, and each done beat is checked field by field.
// ----------------------------------------------------------------------------
module failure_backoff_table_tb;
  import fbt_pkg::*;

  // Unused command code, answered like a query
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic        status;
    logic        blocked;
    logic [31:0] hours;
    logic [3:0]  count;
    logic [3:0]  level;
  } answer_t;

  // Shadow copy of the table plus the queue of answers still owed
  class backoff_shadow;
    bit          tracking;
    bit [3:0]    fails    [SLOTS];
    bit [3:0]    levels   [SLOTS];
    bit [31:0]   retry_at [SLOTS];
    bit [31:0]   level_hours [8] = '{32'd1, 32'd4, 32'd12, 32'd24,
                                     32'd72, 32'd168, 32'd336, 32'd731};
    answer_t     pending [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned invalid_seen;
    int unsigned blocked_seen;
    int unsigned saturated_seen;
    int unsigned wrapped_seen;

    task report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    function void set_tracking(bit value);
      tracking = value;
    endfunction

    // Apply one accepted request to the shadow table and queue its answer
    function void note_request(logic [1:0] cmd, logic [7:0] slot, logic [31:0] now);
      answer_t   ans;
      bit [3:0]  c;
      bit [3:0]  lv;
      bit [32:0] sum;
      ans = '0;
      if (!tracking || int'(slot) >= SLOTS) begin
        ans.status = STATUS_INVALID;
        invalid_seen++;
      end else begin
        case (cmd)
          CMD_FAIL: begin
            c   = (fails[slot] < COUNT_MAX) ? fails[slot] + 4'd1 : fails[slot];
            lv  = (c > LEVEL_MAX) ? LEVEL_MAX : c;
            sum = {1'b0, now} + {1'b0, level_hours[3'(lv - 4'd1)]};
            if (sum[32]) wrapped_seen++;
            fails[slot]    = c;
            levels[slot]   = lv;
            retry_at[slot] = sum[31:0];
          end
          CMD_SUCCESS: begin
            fails[slot]    = '0;
            levels[slot]   = '0;
            retry_at[slot] = '0;
          end
          default: ;  // query and spare code leave the entry alone
        endcase
        ans.status = STATUS_OK;
        // blocked state is judged on the entry after the update
        if (fails[slot] != 0 && now < retry_at[slot]) begin
          ans.blocked = 1'b1;
          ans.hours   = retry_at[slot] - now;
          blocked_seen++;
        end
        ans.count = fails[slot];
        ans.level = levels[slot];
        if (fails[slot] == COUNT_MAX) saturated_seen++;
      end
      pending.push_back(ans);
    endfunction

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Match one done beat against the oldest owed answer
    task check_answer(answer_t got);
      answer_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending (%h)", got));
      end else begin
        want = pending.pop_front();
        checked++;
        compare_field("status", 32'(got.status), 32'(want.status));
        compare_field("blocked", 32'(got.blocked), 32'(want.blocked));
        compare_field("hours_until_retry", got.hours, want.hours);
        compare_field("count_after", 32'(got.count), 32'(want.count));
        compare_field("level_after", 32'(got.level), 32'(want.level));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  command;
  logic [7:0]  slot_index;
  logic [31:0] now_hours;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        done;
  logic        status;
  logic        blocked;
  logic [31:0] hours_until_retry;
  logic [3:0]  count_after;
  logic [3:0]  level_after;

  backoff_shadow shadow;
  int            burst_left;
  int unsigned   requests_sent;

  failure_backoff_table dut (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .command           (command),
    .slot_index        (slot_index),
    .now_hours         (now_hours),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .done              (done),
    .status            (status),
    .blocked           (blocked),
    .hours_until_retry (hours_until_retry),
    .count_after       (count_after),
    .level_after       (level_after)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result monitor: every done beat is checked at the closing edge
  always @(posedge clk) begin
    if (!rst && done)
      shadow.check_answer({status, blocked, hours_until_retry, count_after, level_after});
  end

  // One request beat; the sender idles between bursts of random length
  task send_request(logic [1:0] cmd, logic [7:0] slot, logic [31:0] now);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
      end
      case ($urandom_range(0, 9))
        0:       burst_left = $urandom_range(60, 120);
        1, 2:    burst_left = $urandom_range(9, 40);
        default: burst_left = $urandom_range(1, 8);
      endcase
    end
    burst_left--;
    @(negedge clk);
    start      <= 1'b1;
    command    <= cmd;
    slot_index <= slot;
    now_hours  <= now;
    do @(posedge clk); while (busy);
    shadow.note_request(cmd, slot, now);
    requests_sent++;
  endtask

  // Let every owed answer come back before touching the register
  task drain();
    @(negedge clk);
    start <= 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_tracking(bit value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    shadow.set_tracking(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: mostly failure runs on one slot with queries around the
  // retry window, usually closed by a success; the rest is unrelated noise
  task random_phase(int target);
    int          issued;
    int          runs;
    logic [31:0] wall;
    logic [7:0]  slot;
    issued = 0;
    case ($urandom_range(0, 3))
      0:       wall = $urandom_range(0, 1000);
      1:       wall = 32'hFFFF_FFFF - $urandom_range(0, 3000);
      default: wall = $urandom;
    endcase
    while (issued < target) begin
      if ($urandom_range(0, 99) < 15) begin
        send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom);
        issued++;
      end else begin
        case ($urandom_range(0, 9))
          0:       slot = 8'd0;
          1:       slot = 8'd255;
          default: slot = 8'($urandom_range(0, 255));
        endcase
        runs = $urandom_range(1, 18);
        repeat (runs) begin
          send_request(CMD_FAIL, slot, wall);
          issued++;
          if ($urandom_range(0, 1)) begin
            send_request(($urandom_range(0, 9) == 0) ? CMD_SPARE : CMD_QUERY, slot,
                         wall + $urandom_range(0, 800));
            issued++;
          end
          wall = wall + $urandom_range(0, 400);
        end
        if ($urandom_range(0, 9) < 7) begin
          send_request(CMD_SUCCESS, slot, wall);
          send_request(CMD_QUERY, slot, wall);
          issued += 2;
        end
      end
    end
  endtask

  // Main sequence
  initial begin
    int p;
    bit en;
    rst           = 1'b1;
    start         = 1'b0;
    command       = CMD_QUERY;
    slot_index    = '0;
    now_hours     = '0;
    cfg_valid     = 1'b0;
    cfg_data      = 1'b0;
    burst_left    = 0;
    requests_sent = 0;
    shadow        = new;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Tracking off: everything answers invalid
    write_tracking(1'b0);
    send_request(CMD_FAIL, 8'd255, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, 8'd0, 32'h0);
    drain();

    // Tracking on: walk slot 0 through every level and into count saturation
    write_tracking(1'b1);
    for (p = 0; p < 16; p++)
      send_request(CMD_FAIL, 8'd0, 32'(p));
    send_request(CMD_QUERY, 8'd0, 32'hFFFF_FFFF);
    send_request(CMD_SPARE, 8'd0, 32'd20);
    send_request(CMD_SUCCESS, 8'd0, 32'd0);
    // retry sum wraps past 32 bits, so the slot reads as not blocked
    send_request(CMD_FAIL, 8'd255, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, 8'd255, 32'h8000_0000);
    drain();

    // Random phases; the store must survive tracking going off and on again
    for (p = 0; p < 6; p++) begin
      en = !(p == 2 || p == 4);
      write_tracking(en);
      random_phase(en ? 330 : 30);
      drain();
    end

    repeat (8) @(posedge clk);
    $display("%0d requests sent, %0d answers checked: %0d invalid, %0d blocked",
             requests_sent, shadow.checked, shadow.invalid_seen, shadow.blocked_seen);
    $display("%0d answers at a saturated count, %0d failures wrapped the retry time",
             shadow.saturated_seen, shadow.wrapped_seen);
    if (shadow.mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // Watchdog
  initial begin
    #500000;
    $display("timeout: run did not complete");
    $display("FAILED: results differ");
    $finish;
  end

endmodule
